>>> sv/mssd_pkg.sv
// package for the multiplexed seven-segment driver
// types, register indexes, reset values and the segment font; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mssd_pkg;

  localparam int NUM_DISPLAYS_DEFAULT = 4;
  localparam int STORE_DEPTH = 4;
  localparam int DIV_BITS_PER_CYCLE = 4;

  localparam logic [7:0] ALL_OFF = 8'hFF;

  localparam logic [1:0] REG_NUMBER_BASE    = 2'd0;
  localparam logic [1:0] REG_DWELL_TICKS    = 2'd1;
  localparam logic [1:0] REG_COUNT_MODE     = 2'd2;
  localparam logic [1:0] REG_COUNT_INTERVAL = 2'd3;

  localparam logic [4:0]  RESET_NUMBER_BASE    = 5'd10;
  localparam logic [15:0] RESET_DWELL_TICKS    = 16'd100;
  localparam logic        RESET_COUNT_MODE     = 1'b0;
  localparam logic [15:0] RESET_COUNT_INTERVAL = 16'd1000;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  typedef struct packed {
    logic do_tick;
    logic load_value;
    logic load_counter;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic blank;
    logic reload;
    logic count_mode;
    logic div_done;
  } status_t;

  function automatic logic [7:0] font_n(input logic [3:0] d);
    logic [7:0] seg;
    unique case (d)
      4'h0: seg = 8'hC0;
      4'h1: seg = 8'hF9;
      4'h2: seg = 8'hA4;
      4'h3: seg = 8'hB0;
      4'h4: seg = 8'h99;
      4'h5: seg = 8'h92;
      4'h6: seg = 8'h82;
      4'h7: seg = 8'hF8;
      4'h8: seg = 8'h80;
      4'h9: seg = 8'h90;
      4'hA: seg = 8'h88;
      4'hB: seg = 8'h83;
      4'hC: seg = 8'hC6;
      4'hD: seg = 8'hA1;
      4'hE: seg = 8'h86;
      default: seg = 8'h8E;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

>>> sv/mssd_ctrl.sv
// controller for the multiplexed seven-segment driver
// request handshake, output valid and the divide sequence; uses mssd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mssd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              kind,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire mssd_pkg::status_t status,
  output mssd_pkg::cmd_t         cmd
);

  mssd_pkg::state_t state;
  mssd_pkg::state_t state_next;
  logic             out_valid_next;
  logic             accept;

  assign in_ready = (state == mssd_pkg::S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      mssd_pkg::S_IDLE: begin
        if (cmd.load_value || cmd.load_counter) begin
          state_next = mssd_pkg::S_DIV;
        end
      end
      mssd_pkg::S_DIV: begin
        if (status.div_done) begin
          state_next = mssd_pkg::S_IDLE;
        end
      end
      default: state_next = mssd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.do_tick      = accept && (kind == mssd_pkg::KIND_TICK);
    cmd.load_value   = accept && (kind == mssd_pkg::KIND_LOAD) && !status.count_mode;
    cmd.load_counter = cmd.do_tick && status.blank && status.count_mode && status.reload;
    cmd.div_step     = (state == mssd_pkg::S_DIV);
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.do_tick) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mssd_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == mssd_pkg::S_DIV && !status.div_done) |=> (state == mssd_pkg::S_DIV))
    else $error("divide sequence left early");

  a_no_request_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == mssd_pkg::S_DIV) |-> (!cmd.do_tick && !cmd.load_value))
    else $error("request taken during divide");

  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.do_tick |=> out_valid)
    else $error("tick without result");

endmodule

`default_nettype wire

>>> sv/mssd_dp.sv
// datapath for the multiplexed seven-segment driver
// config registers, scan counters, digit store, radix divider, output register; uses mssd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mssd_dp #(
  parameter int NUM_DISPLAYS = mssd_pkg::NUM_DISPLAYS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic [15:0]       value,
  input  wire mssd_pkg::cmd_t    cmd,
  output mssd_pkg::status_t      status,
  output logic [7:0]             segments_n,
  output logic [7:0]             display_select_n,
  output logic [1:0]             digit_index
);

  localparam int PW = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;
  localparam int SW = $clog2(mssd_pkg::STORE_DEPTH);
  localparam int CW = $clog2(16 / mssd_pkg::DIV_BITS_PER_CYCLE);

  logic [4:0]  number_base;
  logic [15:0] dwell_ticks;
  logic        count_mode;
  logic [15:0] count_interval;

  logic [3:0]  digit_store [mssd_pkg::STORE_DEPTH];
  logic [PW-1:0] scan_position;
  logic [15:0] dwell_counter;
  logic [15:0] up_counter;
  logic [15:0] step_counter;

  logic [15:0] work;
  logic [3:0]  rem;
  logic [SW-1:0] digit_cnt;
  logic [CW-1:0] step_cnt;

  logic [4:0]  base_eff;
  logic [15:0] dwell_eff;
  logic [2:0]  pos_ext;
  logic [3:0]  digit;
  logic [4:0]  rem_step;
  logic [15:0] work_step;

  assign base_eff  = (number_base < 5'd2) ? 5'd2 :
                     (number_base > 5'd16) ? 5'd16 : number_base;
  assign dwell_eff = (dwell_ticks == 16'd0) ? 16'd1 : dwell_ticks;
  assign pos_ext   = 3'(scan_position);
  assign digit     = (pos_ext < 3'(mssd_pkg::STORE_DEPTH)) ? digit_store[pos_ext[SW-1:0]] : 4'd0;

  assign status.blank      = (dwell_counter >= dwell_eff);
  assign status.reload     = (step_counter >= count_interval);
  assign status.count_mode = count_mode;
  assign status.div_done   = cmd.div_step && (digit_cnt == SW'(mssd_pkg::STORE_DEPTH - 1))
                             && (step_cnt == '1);

  // restoring division, several quotient bits per cycle
  always_comb begin
    rem_step  = {1'b0, rem};
    work_step = work;
    for (int i = 0; i < mssd_pkg::DIV_BITS_PER_CYCLE; i++) begin
      rem_step  = {rem_step[3:0], work_step[15]};
      work_step = {work_step[14:0], 1'b0};
      if (rem_step >= base_eff) begin
        rem_step     = rem_step - base_eff;
        work_step[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base    <= mssd_pkg::RESET_NUMBER_BASE;
      dwell_ticks    <= mssd_pkg::RESET_DWELL_TICKS;
      count_mode     <= mssd_pkg::RESET_COUNT_MODE;
      count_interval <= mssd_pkg::RESET_COUNT_INTERVAL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mssd_pkg::REG_NUMBER_BASE:    number_base    <= cfg_data[4:0];
        mssd_pkg::REG_DWELL_TICKS:    dwell_ticks    <= cfg_data;
        mssd_pkg::REG_COUNT_MODE:     count_mode     <= cfg_data[0];
        mssd_pkg::REG_COUNT_INTERVAL: count_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= '0;
      dwell_counter <= '0;
      up_counter    <= '0;
      step_counter  <= '0;
    end else if (cmd.do_tick) begin
      if (!status.blank) begin
        dwell_counter <= dwell_counter + 16'd1;
      end else begin
        dwell_counter <= '0;
        scan_position <= (scan_position == PW'(NUM_DISPLAYS - 1)) ? '0 : scan_position + 1'b1;
        if (count_mode) begin
          if (status.reload) begin
            up_counter   <= up_counter + 16'd1;
            step_counter <= '0;
          end else begin
            step_counter <= step_counter + 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_tick) begin
      digit_index <= pos_ext[1:0];
      if (status.blank) begin
        segments_n       <= mssd_pkg::ALL_OFF;
        display_select_n <= mssd_pkg::ALL_OFF;
      end else begin
        segments_n       <= mssd_pkg::font_n(digit);
        display_select_n <= ~(8'd1 << pos_ext);
      end
    end
  end

  // digit extraction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mssd_pkg::STORE_DEPTH; i++) begin
        digit_store[i] <= '0;
      end
      digit_cnt <= '0;
      step_cnt  <= '0;
      rem       <= '0;
    end else if (cmd.load_value || cmd.load_counter) begin
      work      <= cmd.load_value ? value : up_counter;
      rem       <= '0;
      digit_cnt <= '0;
      step_cnt  <= '0;
    end else if (cmd.div_step) begin
      work     <= work_step;
      step_cnt <= step_cnt + 1'b1;
      if (step_cnt == '1) begin
        digit_store[digit_cnt] <= rem_step[3:0];
        rem                    <= '0;
        digit_cnt              <= digit_cnt + 1'b1;
      end else begin
        rem <= rem_step[3:0];
      end
    end
  end

  a_blank_all_off: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_tick && status.blank) |=>
      (segments_n == mssd_pkg::ALL_OFF && display_select_n == mssd_pkg::ALL_OFF))
    else $error("blanking tick drove a display");

endmodule

`default_nettype wire

>>> sv/multiplexed_seven_segment_driver_top.sv
// top level of the multiplexed seven-segment driver
// joins mssd_ctrl and mssd_dp; uses mssd_pkg
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_ready       kind, value
//   out      output     out_valid / out_ready     segments_n, display_select_n, digit_index
//   cfg      input      cfg_write                 cfg_index, cfg_data
//
// a tick request's result is registered in the output register
// a load request outside count mode is accepted, then runs the radix divider
// (four bits per cycle, four digits); a tick that reloads the up-counter does the same
// a request is taken only while idle and the output register is empty or draining
// that cycle; synchronous reset restores the config defaults and clears digits and counters
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_seven_segment_driver_top #(
  parameter int NUM_DISPLAYS = mssd_pkg::NUM_DISPLAYS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [15:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       segments_n,
  output logic [7:0]       display_select_n,
  output logic [1:0]       digit_index
);

  mssd_pkg::cmd_t    cmd;
  mssd_pkg::status_t status;

  mssd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mssd_dp #(
    .NUM_DISPLAYS (NUM_DISPLAYS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .value            (value),
    .cmd              (cmd),
    .status           (status),
    .segments_n       (segments_n),
    .display_select_n (display_select_n),
    .digit_index      (digit_index)
  );

endmodule

`default_nettype wire

>>> sim/tb.sv
// testbench for the multiplexed seven-segment driver top level
// a scoreboard class predicts each display frame from accepted requests; uses mssd_pkg
`timescale 1ns / 1ps

module tb;
  import mssd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 127;

  typedef struct packed {
    logic [7:0] segments_n;
    logic [7:0] display_select_n;
    logic [1:0] digit_index;
  } display_frame_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_SPARSE
  } flow_t;

  class segment_scoreboard;
    display_frame_t expected_frames[$];
    int mismatches;
    logic [4:0] base_reg;
    logic [15:0] dwell_reg;
    logic mode_reg;
    logic [15:0] interval_reg;
    logic [3:0] digits[4];
    logic [1:0] scan_pos;
    logic [15:0] dwell_count;
    logic [15:0] up_count;
    logic [15:0] step_count;

    function new();
      mismatches = 0;
      base_reg = RESET_NUMBER_BASE;
      dwell_reg = RESET_DWELL_TICKS;
      mode_reg = RESET_COUNT_MODE;
      interval_reg = RESET_COUNT_INTERVAL;
      foreach (digits[i]) digits[i] = 4'd0;
      scan_pos = 2'd0;
      dwell_count = 16'd0;
      up_count = 16'd0;
      step_count = 16'd0;
    endfunction

    function logic [7:0] glyph_n(logic [3:0] d);
      logic [7:0] g;
      case (d)
        4'h0: g = 8'hC0;
        4'h1: g = 8'hF9;
        4'h2: g = 8'hA4;
        4'h3: g = 8'hB0;
        4'h4: g = 8'h99;
        4'h5: g = 8'h92;
        4'h6: g = 8'h82;
        4'h7: g = 8'hF8;
        4'h8: g = 8'h80;
        4'h9: g = 8'h90;
        4'hA: g = 8'h88;
        4'hB: g = 8'h83;
        4'hC: g = 8'hC6;
        4'hD: g = 8'hA1;
        4'hE: g = 8'h86;
        default: g = 8'h8E;
      endcase
      return g;
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_NUMBER_BASE: base_reg = data[4:0];
        REG_DWELL_TICKS: dwell_reg = data;
        REG_COUNT_MODE: mode_reg = data[0];
        REG_COUNT_INTERVAL: interval_reg = data;
        default: ;
      endcase
    endfunction

    function void split_into_digits(logic [15:0] v);
      int radix;
      int rest;
      radix = base_reg;
      if (radix < 2) radix = 2;
      if (radix > 16) radix = 16;
      rest = v;
      for (int i = 0; i < 4; i++) begin
        digits[i] = 4'(rest % radix);
        rest = rest / radix;
      end
    endfunction

    // accepted request: loads outside count mode update the digits, ticks queue one frame
    function void note_request(logic k, logic [15:0] v);
      display_frame_t f;
      int dwell_eff;
      if (k == KIND_LOAD) begin
        if (!mode_reg) split_into_digits(v);
        return;
      end
      dwell_eff = (dwell_reg == 16'd0) ? 1 : int'(dwell_reg);
      f.digit_index = scan_pos;
      if (int'(dwell_count) < dwell_eff) begin
        f.segments_n = glyph_n(digits[scan_pos]);
        f.display_select_n = ~(8'd1 << scan_pos);
        dwell_count = dwell_count + 16'd1;
      end else begin
        f.segments_n = ALL_OFF;
        f.display_select_n = ALL_OFF;
        dwell_count = 16'd0;
        scan_pos = scan_pos + 2'd1;
        if (mode_reg) begin
          if (step_count >= interval_reg) begin
            split_into_digits(up_count);
            up_count = up_count + 16'd1;
            step_count = 16'd0;
          end else begin
            step_count = step_count + 16'd1;
          end
        end
      end
      expected_frames.push_back(f);
    endfunction

    function void check_result(logic [7:0] seg, logic [7:0] sel, logic [1:0] idx);
      display_frame_t f;
      if (expected_frames.size() == 0) begin
        $error("unexpected frame: segments_n %02h display_select_n %02h digit_index %0d",
               seg, sel, idx);
        mismatches++;
        return;
      end
      f = expected_frames.pop_front();
      if (seg !== f.segments_n) begin
        $error("segments_n: expected %02h, actual %02h", f.segments_n, seg);
        mismatches++;
      end
      if (sel !== f.display_select_n) begin
        $error("display_select_n: expected %02h, actual %02h", f.display_select_n, sel);
        mismatches++;
      end
      if (idx !== f.digit_index) begin
        $error("digit_index: expected %0d, actual %0d", f.digit_index, idx);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_NUMBER_BASE;
  logic [15:0] cfg_data = 16'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = KIND_TICK;
  logic [15:0] value = 16'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] segments_n;
  logic [7:0] display_select_n;
  logic [1:0] digit_index;

  logic hold_request = 1'b0;
  int burst_left = 0;
  int quiet_cycles = 0;
  segment_scoreboard sb = new();

  multiplexed_seven_segment_driver_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .segments_n(segments_n),
    .display_select_n(display_select_n),
    .digit_index(digit_index)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(segments_n, display_select_n, digit_index);
      if (in_valid && in_ready) sb.note_request(kind, value);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int hold_left;
    int mode_left;
    int beat;
    bit hold_taken;
    flow_t flow;
    hold_left = 0;
    mode_left = 0;
    beat = 0;
    hold_taken = 1'b0;
    flow = READY_ALWAYS;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        flow = flow_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      beat++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (flow)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_COIN: out_ready <= 1'($urandom_range(0, 1));
          READY_PERIODIC: out_ready <= (beat % 5) != 0;
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic k, input logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_frames.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] base, input logic [15:0] dwell,
                                input logic [15:0] mode, input logic [15:0] interval);
    write_register(REG_NUMBER_BASE, base);
    write_register(REG_DWELL_TICKS, dwell);
    write_register(REG_COUNT_MODE, mode);
    write_register(REG_COUNT_INTERVAL, interval);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(KIND_TICK, 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_random_items(input int count);
    int sent;
    int pick;
    logic k;
    logic [15:0] v;
    sent = 0;
    while (sent < count) begin
      k = ($urandom_range(0, 99) < (sb.mode_reg ? 6 : 22)) ? KIND_LOAD : KIND_TICK;
      pick = $urandom_range(0, 9);
      if (pick == 0) v = 16'd0;
      else if (pick == 1) v = 16'hFFFF;
      else if (pick < 4) v = 16'($urandom_range(0, 255));
      else v = 16'($urandom_range(0, 65535));
      send_item(k, v);
      if (k == KIND_TICK || !sb.mode_reg) sent++;
    end
  endtask

  initial begin
    logic [15:0] base;
    logic [15:0] dwell;
    logic [15:0] mode;
    logic [15:0] interval;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: decimal split, long dwell
    send_item(KIND_LOAD, 16'd4321);
    send_ticks(2);
    wait_until_idle();

    // hex, one tick per display, all-ones and zero values
    write_register(REG_DWELL_TICKS, 16'd1);
    write_register(REG_NUMBER_BASE, 16'd16);
    send_item(KIND_LOAD, 16'hFFFF);
    send_ticks(8);
    send_item(KIND_LOAD, 16'h0000);
    send_ticks(2);
    wait_until_idle();

    // base below range and zero dwell
    write_register(REG_NUMBER_BASE, 16'd0);
    write_register(REG_DWELL_TICKS, 16'd0);
    send_item(KIND_LOAD, 16'd13);
    send_ticks(4);
    wait_until_idle();

    // base above range, counter shown, load ignored, then counter kept on exit
    write_register(REG_NUMBER_BASE, 16'd31);
    write_register(REG_COUNT_MODE, 16'd1);
    write_register(REG_COUNT_INTERVAL, 16'd0);
    send_ticks(2);
    send_item(KIND_LOAD, 16'h1234);
    send_ticks(2);
    wait_until_idle();
    write_register(REG_COUNT_MODE, 16'd0);
    send_ticks(2);
    wait_until_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin base = 16'd2; dwell = 16'd1; mode = 16'd0; interval = 16'd0; end
        1: begin base = 16'd16; dwell = 16'hFFFF; mode = 16'd0; interval = 16'hFFFF; end
        2: begin base = 16'd17; dwell = 16'd0; mode = 16'd1; interval = 16'd0; end
        3: begin base = 16'd1; dwell = 16'd2; mode = 16'd1; interval = 16'hFFFF; end
        4: begin base = 16'd3; dwell = 16'd3; mode = 16'd1; interval = 16'd1; end
        default: begin
          base = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 31))
                                             : 16'($urandom_range(2, 16));
          dwell = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 60))
                                              : 16'($urandom_range(0, 6));
          mode = 16'($urandom_range(0, 1));
          interval = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 4));
        end
      endcase
      apply_settings(base, dwell, mode, interval);
      if (p == 5) hold_request <= 1'b1;
      send_random_items(PHASE_ITEMS);
      wait_until_idle();
    end

    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
